/* rtl/core/lzid_pkg.sv */
// shared types and constants of the lzss image decoder
// used by every module under rtl/core but lzid_ram
`default_nettype none

package lzid_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int DIM_W        = 10;
  localparam int POS_W        = 2 * DIM_W;
  localparam int CFG_DW       = 10;
  localparam int CFG_AW       = 2;
  localparam int DIST_W       = 12;
  localparam int LEN_W        = 6;
  localparam int MIN_MATCH    = 3;

  localparam logic [CFG_AW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MODE   = 2'd2;

  typedef enum logic [1:0] {
    PH_CONTROL,
    PH_ITEM,
    PH_CMD_HIGH
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_COPY_RD,
    ST_COPY_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic parse;
    logic lit_emit;
    logic copy_read;
    logic copy_emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    phase_t phase;
    logic   flag_bit;
    logic   total_zero;
    logic   slot_free;
    logic   fin;
    logic   copy_last;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/lzid_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lzid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lzid_ctrl.sv */
// sequencing state machine of the lzss image decoder
// depends on lzid_pkg
`default_nettype none

module lzid_ctrl import lzid_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !sts.total_zero) begin
          if (sts.phase == PH_ITEM && sts.flag_bit) begin
            state_next = ST_LIT;
          end else if (sts.phase == PH_CMD_HIGH) begin
            state_next = ST_COPY_RD;
          end
        end
      end
      ST_LIT: begin
        if (sts.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_COPY_RD: begin
        state_next = ST_COPY_EMIT;
      end
      ST_COPY_EMIT: begin
        if (sts.slot_free) begin
          state_next = (sts.fin || sts.copy_last) ? ST_IDLE : ST_COPY_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.parse = in_valid && !sts.total_zero;
      end
      ST_LIT: begin
        cmd.lit_emit = sts.slot_free;
      end
      ST_COPY_RD: begin
        cmd.copy_read = 1'b1;
      end
      ST_COPY_EMIT: begin
        cmd.copy_emit = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/lzid_datapath.sv */
// parse registers, pixel position, history window and output register
// depends on lzid_pkg and lzid_ram
`default_nettype none

module lzid_datapath import lzid_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic [7:0]        stream_byte,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             pixel_value,
  output logic                   run_last,
  output logic                   image_done
);

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic              short_length_mode;

  logic [POS_W-1:0]  pixel_position;
  phase_t            parse_phase;
  logic [7:0]        flag_shift;
  logic [3:0]        flags_left;
  logic [7:0]        command_low;

  logic [7:0]        lit_byte;
  logic [DIST_W-1:0] copy_dist;
  logic [LEN_W-1:0]  count;
  logic              src_ok;

  logic [POS_W-1:0]  total;
  logic [POS_W:0]    pos_inc;
  logic              fin;
  logic              emit;
  logic              byte_end;
  logic [7:0]        pix;
  logic [15:0]       cmd_word;
  logic [DIST_W-1:0] dec_dist;
  logic [LEN_W-1:0]  dec_len;
  logic [POS_W-1:0]  src_pos;
  logic [7:0]        rdata;
  logic [3:0]        flags_dec;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= '0;
      image_height      <= '0;
      short_length_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  image_width       <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: image_height      <= cfg_data[DIM_W-1:0];
        CFG_MODE:   short_length_mode <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  assign total   = POS_W'(image_width) * POS_W'(image_height);
  assign pos_inc = {1'b0, pixel_position} + (POS_W+1)'(1);
  assign fin     = pos_inc >= {1'b0, total};
  assign emit    = cmd.lit_emit || cmd.copy_emit;
  assign byte_end = cmd.lit_emit || (count == LEN_W'(1));
  assign pix     = cmd.lit_emit ? lit_byte : (src_ok ? rdata : 8'd0);

  assign cmd_word = {stream_byte, command_low};
  always_comb begin
    if (short_length_mode) begin
      dec_len  = LEN_W'(cmd_word[3:0]) + LEN_W'(MIN_MATCH);
      dec_dist = DIST_W'(cmd_word[15:4]);
    end else begin
      dec_len  = LEN_W'(cmd_word[4:0]) + LEN_W'(MIN_MATCH);
      dec_dist = DIST_W'(cmd_word[15:5]);
    end
  end

  assign src_pos   = pixel_position - POS_W'(copy_dist);
  assign flags_dec = (flags_left != 4'd0) ? flags_left - 4'd1 : 4'd0;

  // parse state and pixel position
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      parse_phase    <= PH_CONTROL;
      flag_shift     <= '0;
      flags_left     <= '0;
      command_low    <= '0;
    end else if (cmd.parse) begin
      case (parse_phase)
        PH_CONTROL: begin
          flag_shift  <= stream_byte;
          flags_left  <= 4'd8;
          parse_phase <= PH_ITEM;
        end
        PH_ITEM: begin
          if (!flag_shift[0]) begin
            command_low <= stream_byte;
            parse_phase <= PH_CMD_HIGH;
          end
        end
        default: ;
      endcase
    end else if (emit) begin
      if (fin) begin
        pixel_position <= '0;
        parse_phase    <= PH_CONTROL;
        flag_shift     <= '0;
        flags_left     <= '0;
        command_low    <= '0;
      end else begin
        pixel_position <= pos_inc[POS_W-1:0];
        if (byte_end) begin
          flag_shift  <= {1'b0, flag_shift[7:1]};
          flags_left  <= flags_dec;
          parse_phase <= (flags_dec != 4'd0) ? PH_ITEM : PH_CONTROL;
        end
      end
    end
  end

  // per-byte working registers
  always_ff @(posedge clk) begin
    if (cmd.parse) begin
      lit_byte <= stream_byte;
      if (parse_phase == PH_CMD_HIGH) begin
        copy_dist <= dec_dist;
        count     <= dec_len;
      end
    end else if (cmd.copy_emit) begin
      count <= count - LEN_W'(1);
    end
    if (cmd.copy_read) begin
      src_ok <= (copy_dist != '0) && (POS_W'(copy_dist) <= pixel_position)
                && ((POS_W+1)'(copy_dist) <= (POS_W+1)'(WINDOW_DEPTH));
    end
  end

  lzid_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (emit),
    .waddr (pixel_position[WIN_AW-1:0]),
    .wdata (pix),
    .re    (cmd.copy_read),
    .raddr (src_pos[WIN_AW-1:0]),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_value <= pix;
      run_last    <= byte_end || fin;
      image_done  <= fin;
    end
  end

  always_comb begin
    sts.phase      = parse_phase;
    sts.flag_bit   = flag_shift[0];
    sts.total_zero = (total == '0);
    sts.slot_free  = !out_valid || out_ready;
    sts.fin        = fin;
    sts.copy_last  = (count == LEN_W'(1));
  end

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("pixel emitted over an untaken item");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_emit |-> (count != '0))
    else $error("copy pixel emitted with no length left");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && image_done) |-> run_last)
    else $error("final pixel of image not marked as last of its byte");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (emit && fin) |=> (pixel_position == '0 && parse_phase == PH_CONTROL))
    else $error("decoder did not restart after final pixel");

endmodule

`default_nettype wire

/* rtl/core/lzss_image_decoder_top.sv */
// top level of the lzss image decoder: controller plus datapath
// depends on lzid_pkg, lzid_ctrl, lzid_datapath
`default_nettype none

// Decodes an LZSS byte stream into 8-bit pixels of an image of
// image_width x image_height. Control bytes and the low bytes of copy
// commands are only accepted; a literal is accepted, then emitted; a copy
// command of n pixels (3 to 34, or 3 to 18 in short length mode) is
// accepted, then each copied pixel is a read of the history window and then
// its write back, so overlapping copies see their own output. An output
// stall holds the pending pixel. The window needs no clearing after reset:
// reads are limited to pixels already written in the current image, anything
// earlier reads as 0. With width or height zero every byte is taken and dropped.
module lzss_image_decoder_top import lzid_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        stream_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             pixel_value,
  output logic                   run_last,
  output logic                   image_done
);

  cmd_t cmd;
  sts_t sts;

  lzid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzid_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .stream_byte (stream_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pixel_value),
    .run_last    (run_last),
    .image_done  (image_done)
  );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench of lzss_image_decoder_top: directed stream table, then random streams
// depends on lzid_pkg and the decoder rtl under rtl/core
`timescale 1ns / 1ps

module tb_top;
  import lzid_pkg::*;

  localparam int LAT_CYCLES      = 80;
  localparam int ITEMS_PER_PHASE = 16;
  localparam int PRESSURE_AT     = 80;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       done;
  } pixel_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } chk_t;

  typedef struct packed {
    logic       is_cfg;
    logic [9:0] w;
    logic [9:0] h;
    logic       mode;
    logic [7:0] b;
    chk_t       chk;
    pixel_t     px;
  } stim_row_t;

  logic                clk;
  logic                rst         = 1'b1;
  logic                cfg_we      = 1'b0;
  logic [CFG_AW-1:0]   cfg_index   = CFG_WIDTH;
  logic [CFG_DW-1:0]   cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [7:0]          stream_byte = 8'h00;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [7:0]          pixel_value;
  logic                run_last;
  logic                image_done;

  // decoder mirror
  logic [7:0]  win_mem [WINDOW_DEPTH];
  int unsigned pix_pos;
  phase_t      dec_phase;
  logic [7:0]  dec_flags;
  int unsigned dec_flags_left;
  logic [7:0]  dec_cmd_low;
  int unsigned img_w;
  int unsigned img_h;
  logic        short_mode;

  pixel_t      pred_burst[$];
  pixel_t      expected_pixels[$];
  stim_row_t   stim_rows[$];

  int send_idle_pct = 34;
  int recv_idle_pct = 57;
  int fail_count = 0;
  int bytes_sent = 0;
  int pixels_checked = 0;
  int images_done = 0;
  int settings_used = 0;

  lzss_image_decoder_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pixel_value),
    .run_last    (run_last),
    .image_done  (image_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("lzss_image_decoder_top regression: fail");
    $finish;
  end

  function automatic pixel_t store_pixel(input logic [7:0] v, input int unsigned total);
    pixel_t e;
    win_mem[WIN_AW'(pix_pos)] = v;
    pix_pos = pix_pos + 1;
    e.value = v;
    e.last  = 1'b0;
    e.done  = (pix_pos >= total);
    return e;
  endfunction

  // works out the pixels one stream byte produces, leaves them in pred_burst
  function automatic void decode_byte(input logic [7:0] b);
    int unsigned total, len, copy_dist, i;
    logic [15:0] cmd;
    logic [7:0]  v;
    pixel_t      e, pend;
    bit          have, fin;
    pred_burst.delete();
    have  = 1'b0;
    fin   = 1'b0;
    pend  = '0;
    total = img_w * img_h;
    if (total == 0) return;
    case (dec_phase)
      PH_CONTROL: begin
        dec_flags      = b;
        dec_flags_left = 8;
        dec_phase      = PH_ITEM;
        return;
      end
      PH_ITEM: begin
        if (!dec_flags[0]) begin
          dec_cmd_low = b;
          dec_phase   = PH_CMD_HIGH;
          return;
        end
        pend = store_pixel(b, total);
        have = 1'b1;
        fin  = pend.done;
      end
      default: begin
        cmd = {b, dec_cmd_low};
        if (short_mode) begin
          len       = 32'(cmd[3:0]);
          copy_dist = 32'(cmd[15:4]);
        end else begin
          len       = 32'(cmd[4:0]);
          copy_dist = 32'(cmd[15:5]);
        end
        len = len + MIN_MATCH;
        // byte by byte, so an overlapping copy sees its own output
        for (i = 0; i < len && !fin; i++) begin
          v = 8'h00;
          if (copy_dist != 0 && copy_dist <= pix_pos && copy_dist <= WINDOW_DEPTH)
            v = win_mem[WIN_AW'(pix_pos - copy_dist)];
          e = store_pixel(v, total);
          if (have) pred_burst.push_back(pend);
          pend = e;
          have = 1'b1;
          fin  = e.done;
        end
      end
    endcase
    if (fin) begin
      pix_pos        = 0;
      dec_phase      = PH_CONTROL;
      dec_flags      = 8'h00;
      dec_flags_left = 0;
      dec_cmd_low    = 8'h00;
    end else begin
      dec_flags = dec_flags >> 1;
      if (dec_flags_left > 0) dec_flags_left--;
      dec_phase = (dec_flags_left != 0) ? PH_ITEM : PH_CONTROL;
    end
    if (have) begin
      pend.last = 1'b1;
      pred_burst.push_back(pend);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input chk_t chk, input pixel_t fixed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_byte(b);
    case (chk)
      CHK_MODEL: foreach (pred_burst[i]) expected_pixels.push_back(pred_burst[i]);
      CHK_ONE:   expected_pixels.push_back(fixed);
      default: ;
    endcase
    bytes_sent++;
  endtask

  // block drained, with time for a copy that yields nothing more
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  task automatic set_image(input logic [9:0] w, input logic [9:0] h, input logic m);
    logic [8:0] pad;
    wait_idle();
    pad = 9'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    img_w = 32'(w);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    img_h = 32'(h);
    // upper bits of the mode write are junk, only bit 0 counts
    cfg_index <= CFG_MODE;
    cfg_data  <= {pad, m};
    @(posedge clk);
    short_mode = m;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic void add_cfg(input logic [9:0] w, input logic [9:0] h, input logic m);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.w = w;
    r.h = h;
    r.mode = m;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input chk_t chk, input pixel_t px);
    stim_row_t r;
    r = '0;
    r.b = b;
    r.chk = chk;
    r.px = px;
    stim_rows.push_back(r);
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    pixel_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel %0h arrived with none expected", pixel_value);
        fail_count++;
      end else begin
        e = expected_pixels.pop_front();
        if (pixel_value !== e.value) begin
          $error("pixel_value: expected %0h, got %0h", e.value, pixel_value);
          fail_count++;
        end
        if (run_last !== e.last) begin
          $error("run_last: expected %0b, got %0b", e.last, run_last);
          fail_count++;
        end
        if (image_done !== e.done) begin
          $error("image_done: expected %0b, got %0b", e.done, image_done);
          fail_count++;
        end
        pixels_checked++;
        if (e.done) images_done++;
      end
    end
  end

  initial begin : stimulus
    int unsigned maxd, copy_dist, lenr, r;
    int          counted, guard, ph, k, n_bytes;
    logic [15:0] cmd;
    logic [7:0]  b, cmd_hi;
    logic [9:0]  w, h;
    logic        m;
    pixel_t      none;

    none           = '0;
    cmd_hi         = 8'h00;
    counted        = 0;
    pix_pos        = 0;
    dec_phase      = PH_CONTROL;
    dec_flags      = 8'h00;
    dec_flags_left = 0;
    dec_cmd_low    = 8'h00;
    img_w          = 0;
    img_h          = 0;
    short_mode     = 1'b0;

    // size zero after reset: bytes are swallowed
    add_byte(8'hff, CHK_NONE, none);
    add_byte(8'h00, CHK_NONE, none);
    // 4x2 image: literal, overlapping copy, zero distance copy ends it
    add_cfg(10'd4, 10'd2, 1'b0);
    add_byte(8'h01, CHK_NONE, none);
    add_byte(8'hff, CHK_ONE, '{value: 8'hff, last: 1'b1, done: 1'b0});
    add_byte(8'h20, CHK_NONE, none);
    add_byte(8'h00, CHK_MODEL, none);
    add_byte(8'h01, CHK_NONE, none);
    add_byte(8'h00, CHK_MODEL, none);
    // restart: longest copy reaching before the image start, cut at the end
    add_byte(8'h00, CHK_NONE, none);
    add_byte(8'hbf, CHK_NONE, none);
    add_byte(8'h00, CHK_MODEL, none);
    // largest image, short length mode, widest distance
    add_cfg(10'd1023, 10'd1023, 1'b1);
    add_byte(8'h03, CHK_NONE, none);
    add_byte(8'h00, CHK_ONE, '{value: 8'h00, last: 1'b1, done: 1'b0});
    add_byte(8'hff, CHK_ONE, '{value: 8'hff, last: 1'b1, done: 1'b0});
    add_byte(8'h2f, CHK_NONE, none);
    add_byte(8'h00, CHK_MODEL, none);
    add_byte(8'hf0, CHK_NONE, none);
    add_byte(8'hff, CHK_MODEL, none);
    // size shrunk below the position mid-image: next pixel finishes it
    add_cfg(10'd4, 10'd5, 1'b1);
    add_byte(8'h00, CHK_NONE, none);
    add_byte(8'h00, CHK_MODEL, none);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg)
        set_image(stim_rows[i].w, stim_rows[i].h, stim_rows[i].mode);
      else
        send_byte(stim_rows[i].b, stim_rows[i].chk, stim_rows[i].px);
    end

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin w = 10'd3;    h = 10'd5;    m = 1'b0; end
        1: begin w = 10'd0;    h = 10'd1023; m = 1'b1; end
        2: begin w = 10'd1023; h = 10'd0;    m = 1'b0; end
        3: begin w = 10'd1023; h = 10'd1023; m = 1'b1; end
        default: begin
          w = 10'($urandom_range(12, 1));
          h = 10'($urandom_range(12, 1));
          m = 1'($urandom);
        end
      endcase
      set_image(w, h, m);
      if (w == 0 || h == 0) begin
        n_bytes = $urandom_range(6, 3);
        for (k = 0; k < n_bytes; k++) send_byte(8'($urandom), CHK_MODEL, none);
      end else begin
        for (k = 0; k < ITEMS_PER_PHASE; k++) begin
          if (counted == 43) begin
            send_idle_pct = 57;
            recv_idle_pct = 34;
          end else if (counted == 86) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
          if (counted == PRESSURE_AT) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (expected_pixels.size() != 0);
          end
          // mostly well-formed commands, one item in ten is noise
          if ($urandom_range(9) == 0) begin
            b = 8'($urandom);
          end else begin
            case (dec_phase)
              PH_CONTROL: b = 8'($urandom);
              PH_ITEM: begin
                if (dec_flags[0]) begin
                  b = 8'($urandom);
                end else begin
                  maxd = short_mode ? 4095 : 2047;
                  r    = $urandom_range(99);
                  if (r < 15)
                    copy_dist = 0;
                  else if (r < 30 || pix_pos == 0)
                    copy_dist = $urandom_range(maxd, 1);
                  else
                    copy_dist = $urandom_range((pix_pos < maxd) ? pix_pos : maxd, 1);
                  lenr = $urandom;
                  if (short_mode)
                    cmd = 16'((copy_dist << 4) | (lenr & 32'h0f));
                  else
                    cmd = 16'((copy_dist << 5) | (lenr & 32'h1f));
                  b      = cmd[7:0];
                  cmd_hi = cmd[15:8];
                end
              end
              default: b = cmd_hi;
            endcase
          end
          send_byte(b, CHK_MODEL, none);
          counted++;
        end
      end
    end

    in_valid <= 1'b0;
    guard = 0;
    while (expected_pixels.size() != 0 && guard < 500000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LAT_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", expected_pixels.size());
      fail_count++;
    end

    $display("covered %0d stream bytes over %0d size settings in both length modes",
             bytes_sent, settings_used);
    $display("checked %0d pixels, %0d images ran to completion", pixels_checked, images_done);
    if (fail_count == 0) begin
      $display("lzss_image_decoder_top regression: pass");
    end else begin
      $display("lzss_image_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lzid_pkg.sv
rtl/core/lzid_ram.sv
rtl/core/lzid_ctrl.sv
rtl/core/lzid_datapath.sv
rtl/core/lzss_image_decoder_top.sv
sim/tb_top.sv
